/* sv/sdm_pkg.sv */
// ----------------------------------------------------------------------------
// sdm_pkg
// Shared types, constants and helpers for the scrolling dot-matrix scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package sdm_pkg;

   localparam int COLUMNS   = 64;
   localparam int ROWS      = 8;
   localparam int COL_W     = $clog2(COLUMNS);
   localparam int ROW_W     = 3;
   localparam int PIX_W     = 8;
   localparam int IDX_W     = 6;
   localparam int TICK_W    = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_DIR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS      = 1'b1;

   localparam logic                 DIR_RESET   = 1'b1;
   localparam logic [TICK_W-1:0]    TICKS_RESET = 8'd2;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_REFRESH = 2'd1,
      OP_WRITE   = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SHOW
   } scan_state_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [IDX_W-1:0]   column_index;
      logic [PIX_W-1:0]   column_bits;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]   row_number;
      logic [PIX_W-1:0]   row_pixels;
      logic               first_row;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic               wr_en;
      logic [COL_W-1:0]   wr_addr;
      logic [PIX_W-1:0]   wr_data;
      logic               rd_en;
      logic [COL_W-1:0]   rd_addr;
   } mem_req_type;

   // (base + offset) mod COLUMNS, offset below COLUMNS
   function automatic logic [COL_W-1:0] wrap_col(input logic [COL_W-1:0] base,
                                                 input logic [COL_W:0]   offset);
      logic [COL_W:0] sum;
      sum = {1'b0, base} + offset;
      if (sum >= (COL_W+1)'(COLUMNS)) begin
         sum = sum - (COL_W+1)'(COLUMNS);
      end
      return sum[COL_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* sv/sdm_pattern_mem.sv */
// ----------------------------------------------------------------------------
// sdm_pattern_mem
// Pattern column store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sdm_pattern_mem (
   input  wire logic                        clock,
   input  wire sdm_pkg::mem_req_type        mem_req,
   output      logic [sdm_pkg::PIX_W-1:0]   rd_data
);

   logic [sdm_pkg::PIX_W-1:0] mem [sdm_pkg::COLUMNS];
   logic [sdm_pkg::PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/sdm_scroll_timer.sv */
// ----------------------------------------------------------------------------
// sdm_scroll_timer
// Tick counter and scroll start column.
// ----------------------------------------------------------------------------
`default_nettype none

module sdm_scroll_timer (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         tick,
   input  wire logic [sdm_pkg::TICK_W-1:0]   ticks_per_step,
   output      logic [sdm_pkg::COL_W-1:0]    scroll_start
);

   logic [sdm_pkg::TICK_W-1:0] count_ff, count_in;
   logic [sdm_pkg::COL_W-1:0]  start_ff, start_in;
   logic [sdm_pkg::TICK_W:0]   count_next;

   always_comb begin
      count_in   = count_ff;
      start_in   = start_ff;
      count_next = {1'b0, count_ff} + (sdm_pkg::TICK_W+1)'(1);
      if (tick) begin
         if (count_next > {1'b0, ticks_per_step}) begin
            count_in = '0;
            start_in = sdm_pkg::wrap_col(start_ff, (sdm_pkg::COL_W+1)'(1));
         end else begin
            count_in = count_next[sdm_pkg::TICK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         start_ff <= '0;
      end else begin
         count_ff <= count_in;
         start_ff <= start_in;
      end
   end

   assign scroll_start = start_ff;

endmodule

`default_nettype wire

/* sv/sdm_frame_scan.sv */
// ----------------------------------------------------------------------------
// sdm_frame_scan
// Request decode, window fetch from the pattern store and row emission.
// ----------------------------------------------------------------------------
`default_nettype none

module sdm_frame_scan (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire sdm_pkg::req_type            req_data,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      sdm_pkg::rsp_type            rsp_data,
   input  wire logic                        scroll_dir,
   input  wire logic [sdm_pkg::COL_W-1:0]   scroll_start,
   output      logic                        tick,
   output      sdm_pkg::mem_req_type        mem_req,
   input  wire logic [sdm_pkg::PIX_W-1:0]   rd_data
);

   sdm_pkg::scan_state_type state_ff, state_in;

   logic [sdm_pkg::ROW_W:0]                         fetch_cnt_ff, fetch_cnt_in;
   logic [sdm_pkg::COL_W-1:0]                       start_ff, start_in;
   logic                                            rd_vld_ff, rd_vld_in;
   logic [sdm_pkg::ROW_W-1:0]                       rd_slot_ff, rd_slot_in;
   logic [sdm_pkg::ROWS-1:0][sdm_pkg::PIX_W-1:0]    window_ff;
   logic [sdm_pkg::ROW_W-1:0]                       row_ff, row_in;
   logic                                            rsp_valid_ff, rsp_valid_in;
   sdm_pkg::rsp_type                                rsp_data_ff, rsp_data_in;

   logic                        accept;
   logic                        load;
   logic [sdm_pkg::PIX_W-1:0]   row_byte;

   // horizontal: bit 7-x = bit r of window column x; vertical: column r
   always_comb begin
      row_byte = '0;
      if (scroll_dir) begin
         for (int x = 0; x < sdm_pkg::ROWS; x++) begin
            row_byte[sdm_pkg::PIX_W-1-x] = window_ff[x][row_ff];
         end
      end else begin
         row_byte = window_ff[row_ff];
      end
   end

   always_comb begin
      state_in     = state_ff;
      fetch_cnt_in = fetch_cnt_ff;
      start_in     = start_ff;
      rd_vld_in    = 1'b0;
      rd_slot_in   = rd_slot_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_req      = '0;
      tick         = 1'b0;
      req_ready    = (state_ff == sdm_pkg::ST_IDLE);
      accept       = req_valid & req_ready;
      load         = ~rsp_valid_ff | rsp_ready;

      case (state_ff)
         sdm_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.opcode)
                  sdm_pkg::OP_TICK: begin
                     tick = 1'b1;
                  end
                  sdm_pkg::OP_WRITE: begin
                     mem_req.wr_en   = ({{sdm_pkg::COL_W{1'b0}}, req_data.column_index}
                                        < (sdm_pkg::COL_W+sdm_pkg::IDX_W)'(sdm_pkg::COLUMNS));
                     mem_req.wr_addr = sdm_pkg::COL_W'(req_data.column_index);
                     mem_req.wr_data = req_data.column_bits;
                  end
                  sdm_pkg::OP_REFRESH: begin
                     start_in        = scroll_start;
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = scroll_start;
                     rd_vld_in       = 1'b1;
                     rd_slot_in      = '0;
                     fetch_cnt_in    = (sdm_pkg::ROW_W+1)'(1);
                     state_in        = sdm_pkg::ST_FETCH;
                  end
                  default: begin
                  end
               endcase
            end
         end
         sdm_pkg::ST_FETCH: begin
            if (fetch_cnt_ff < (sdm_pkg::ROW_W+1)'(sdm_pkg::ROWS)) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = sdm_pkg::wrap_col(start_ff,
                                    (sdm_pkg::COL_W+1)'(fetch_cnt_ff));
               rd_vld_in       = 1'b1;
               rd_slot_in      = fetch_cnt_ff[sdm_pkg::ROW_W-1:0];
               fetch_cnt_in    = fetch_cnt_ff + (sdm_pkg::ROW_W+1)'(1);
            end
            if (rd_vld_ff && (rd_slot_ff == sdm_pkg::ROW_W'(sdm_pkg::ROWS-1))) begin
               row_in   = '0;
               state_in = sdm_pkg::ST_SHOW;
            end
         end
         sdm_pkg::ST_SHOW: begin
            if (load) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.row_number = row_ff;
               rsp_data_in.row_pixels = row_byte;
               rsp_data_in.first_row  = (row_ff == '0);
               rsp_data_in.last       = (row_ff == sdm_pkg::ROW_W'(sdm_pkg::ROWS-1));
               row_in                 = row_ff + sdm_pkg::ROW_W'(1);
               if (row_ff == sdm_pkg::ROW_W'(sdm_pkg::ROWS-1)) begin
                  state_in = sdm_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sdm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdm_pkg::ST_IDLE;
         fetch_cnt_ff <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         fetch_cnt_ff <= fetch_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         row_ff       <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      rd_slot_ff  <= rd_slot_in;
      rsp_data_ff <= rsp_data_in;
      if (rd_vld_ff) begin
         window_ff[rd_slot_ff] <= rd_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* sv/scrolling_dot_matrix_scanner_unit.sv */
// ----------------------------------------------------------------------------
// scrolling_dot_matrix_scanner_unit
// Scrolling 8x8 LED matrix scanner over a 64-column pattern store.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   req_*     in         req_valid/req_ready    sdm_pkg::req_type
//   rsp_*     out        rsp_valid/rsp_ready    sdm_pkg::rsp_type
//   csr_*     in         csr_we (no wait)       csr_index, csr_wdata
//
// Tick and write requests complete in the cycle they are accepted.
// A refresh reads the eight window columns through the single read port of
// the pattern store, then emits eight rows, one per cycle while rsp_ready
// is high; no new request is accepted until the last row is loaded.
// rsp holds in an output register; a stalled rsp only pauses row emission.
// Synchronous active-high reset clears control and timer and sets the two
// CSRs to their reset values (horizontal scroll, tick setting 2); the
// pattern store is not cleared and reads garbage until written.
//
`default_nettype none

module scrolling_dot_matrix_scanner_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire sdm_pkg::req_type                  req_data,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      sdm_pkg::rsp_type                  rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [sdm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sdm_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   // configuration registers
   logic                          scroll_dir_ff, scroll_dir_in;
   logic [sdm_pkg::TICK_W-1:0]    ticks_ff, ticks_in;

   logic                          tick;
   logic [sdm_pkg::COL_W-1:0]     scroll_start;
   sdm_pkg::mem_req_type          mem_req;
   logic [sdm_pkg::PIX_W-1:0]     rd_data;

   always_comb begin
      scroll_dir_in = scroll_dir_ff;
      ticks_in      = ticks_ff;
      if (csr_we) begin
         case (csr_index)
            sdm_pkg::CSR_SCROLL_DIR: scroll_dir_in = csr_wdata[0];
            sdm_pkg::CSR_TICKS:      ticks_in      = csr_wdata[sdm_pkg::TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_dir_ff <= sdm_pkg::DIR_RESET;
         ticks_ff      <= sdm_pkg::TICKS_RESET;
      end else begin
         scroll_dir_ff <= scroll_dir_in;
         ticks_ff      <= ticks_in;
      end
   end

   // tick counter and scroll position
   sdm_scroll_timer u_timer (
      .clock          (clock),
      .reset          (reset),
      .tick           (tick),
      .ticks_per_step (ticks_ff),
      .scroll_start   (scroll_start)
   );

   // pattern column store
   sdm_pattern_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // request decode, window fetch, row output
   sdm_frame_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .scroll_dir   (scroll_dir_ff),
      .scroll_start (scroll_start),
      .tick         (tick),
      .mem_req      (mem_req),
      .rd_data      (rd_data)
   );

   // a refresh occupies the block: no request taken on the next cycle
   a_refresh_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.opcode == sdm_pkg::OP_REFRESH)
      |=> !req_ready)
      else $error("request accepted right after a refresh");

   // strobes follow the row number
   a_first_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.first_row == (rsp_data.row_number == '0)))
      else $error("first_row strobe out of step with row number");

   a_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last ==
                     (rsp_data.row_number == sdm_pkg::ROW_W'(sdm_pkg::ROWS-1))))
      else $error("last flag out of step with row number");

   // scroll position stays inside the store
   a_start_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, scroll_start} < (sdm_pkg::COL_W+1)'(sdm_pkg::COLUMNS)))
      else $error("scroll start beyond column count");

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scrolling dot-matrix scanner. A directed script
// (diagonal pattern, both scroll modes, tick pacing, the unused opcode) runs
// first. A store fill and randomized phases at several speed and direction
// settings follow, checked row by row against an in-bench frame predictor.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sdm_pkg::*;

   // Opcode 3 is not decoded by the block: accepted, no state change, no rows
   localparam opcode_type OP_UNUSED = opcode_type'(2'b11);

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 24;

   // One line of the directed script: a register write, or a request with
   // an optional hand-typed frame (pix[r] is the byte of row r)
   typedef struct packed {
      logic                        is_csr;
      logic [CSR_IDX_W-1:0]        csr_idx;
      logic [CSR_DAT_W-1:0]        csr_val;
      req_type                     req;
      logic                        typed;
      logic [ROWS-1:0][PIX_W-1:0]  pix;
   } script_line_type;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   int  failures = 0;
   int  cycles   = 0;
   bit  calm     = 1'b0;   // phase without any idling on either side
   int  stall_left = 0;

   // Frame predictor state: its own image of the store, timer and registers
   logic [PIX_W-1:0]  img_cols [COLUMNS];
   logic [TICK_W-1:0] img_tick;
   logic [COL_W-1:0]  img_start;
   logic              img_horiz;
   logic [TICK_W-1:0] img_step;

   // Rows still owed by the block, oldest first
   rsp_type rows_due [$];

   scrolling_dot_matrix_scanner_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Watchdog: a hang anywhere ends the run as a failure
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t ns: watchdog expired with %0d rows outstanding", $time,
                  rows_due.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Mostly back-to-back, sometimes a short gap, now and then a long gap
   function automatic int idle_len();
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ---------------------------------------------------------------------
   // Frame predictor. Ticks pace the scroll, writes load the store image,
   // a refresh queues eight rows built from the current window.
   // ---------------------------------------------------------------------
   function automatic void predict_request(input req_type r, input logic typed,
                                           input logic [ROWS-1:0][PIX_W-1:0] pix_typed);
      logic [TICK_W:0]             nxt;
      logic [ROWS-1:0][PIX_W-1:0]  frame;
      rsp_type                     row;
      int                          col;
      case (r.opcode)
         OP_TICK: begin
            // 9-bit compare so that a setting of 255 advances on tick 256
            nxt = {1'b0, img_tick} + 1'b1;
            if (nxt > {1'b0, img_step}) begin
               img_tick  = '0;
               img_start = COL_W'((int'(img_start) + 1) % COLUMNS);
            end else begin
               img_tick = nxt[TICK_W-1:0];
            end
         end
         OP_WRITE: begin
            img_cols[r.column_index] = r.column_bits;
         end
         OP_REFRESH: begin
            for (int y = 0; y < ROWS; y++) begin
               if (img_horiz) begin
                  // transpose: column x of the window lands on bit 7-x
                  for (int x = 0; x < 8; x++) begin
                     col = (int'(img_start) + x) % COLUMNS;
                     frame[y][7-x] = img_cols[col][y];
                  end
               end else begin
                  frame[y] = img_cols[(int'(img_start) + y) % COLUMNS];
               end
            end
            if (typed) frame = pix_typed;
            for (int y = 0; y < ROWS; y++) begin
               row.row_number = ROW_W'(y);
               row.row_pixels = frame[y];
               row.first_row  = (y == 0);
               row.last       = (y == ROWS - 1);
               rows_due.push_back(row);
            end
         end
         default: ;   // unused opcode: nothing happens
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request side. Valid rises on a falling edge and holds until accepted;
   // a zero gap keeps valid high straight into the next request.
   // ---------------------------------------------------------------------
   task automatic push_request(input req_type r, input logic typed,
                               input logic [ROWS-1:0][PIX_W-1:0] pix_typed);
      int gap;
      gap = idle_len();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      predict_request(r, typed, pix_typed);
   endtask

   // Drop valid, wait for every owed row, then let the block go quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (rows_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_SCROLL_DIR) img_horiz = val[0];
      else if (idx == CSR_TICKS) img_step = val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Row side: ready toggles with random stalls, rows are checked in order
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready  <= 1'b1;
         stall_left = idle_len();
      end
   end

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : row_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rows_due.size() == 0) begin
            $display("%0t ns: row with none expected, expected nothing, actual %p",
                     $time, rsp_data);
            failures++;
         end else begin
            want = rows_due.pop_front();
            check_field("row_number", want.row_number, rsp_data.row_number);
            check_field("row_pixels", want.row_pixels, rsp_data.row_pixels);
            check_field("first_row",  want.first_row,  rsp_data.first_row);
            check_field("last",       want.last,       rsp_data.last);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Script builders
   // ---------------------------------------------------------------------
   function automatic script_line_type op_line(input opcode_type op,
                                               input logic [IDX_W-1:0] col,
                                               input logic [PIX_W-1:0] bits);
      script_line_type s;
      s = '0;
      s.req.opcode       = op;
      s.req.column_index = col;
      s.req.column_bits  = bits;
      return s;
   endfunction

   function automatic script_line_type typed_refresh(
                                          input logic [ROWS-1:0][PIX_W-1:0] pix);
      script_line_type s;
      s = op_line(OP_REFRESH, '0, '0);
      s.typed = 1'b1;
      s.pix   = pix;
      return s;
   endfunction

   function automatic script_line_type csr_line(input logic [CSR_IDX_W-1:0] idx,
                                                input logic [CSR_DAT_W-1:0] val);
      script_line_type s;
      s = '0;
      s.is_csr  = 1'b1;
      s.csr_idx = idx;
      s.csr_val = val;
      return s;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      roll;
      roll = $urandom_range(0, 99);
      r.column_index = IDX_W'($urandom_range(0, COLUMNS - 1));
      r.column_bits  = PIX_W'($urandom);
      if (roll < 40)      r.opcode = OP_TICK;
      else if (roll < 75) r.opcode = OP_REFRESH;
      else if (roll < 95) r.opcode = OP_WRITE;
      else                r.opcode = OP_UNUSED;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      script_line_type script [$];
      req_type         r;
      logic            dir;
      logic [7:0]      step;

      // predictor after reset; store image stays unread until written
      img_tick  = '0;
      img_start = '0;
      img_horiz = DIR_RESET;
      img_step  = TICKS_RESET;

      // Diagonal in columns 0..7: column x lights row x only.
      // Typed frames list row 7 first, row 0 last.
      for (int x = 0; x < 8; x++)
         script.push_back(op_line(OP_WRITE, IDX_W'(x), PIX_W'(1 << x)));
      // horizontal after reset: row r has bit 7-r set
      script.push_back(typed_refresh({8'h01, 8'h02, 8'h04, 8'h08,
                                      8'h10, 8'h20, 8'h40, 8'h80}));
      script.push_back(csr_line(CSR_SCROLL_DIR, '0));
      // vertical: row r is column r
      script.push_back(typed_refresh({8'h80, 8'h40, 8'h20, 8'h10,
                                      8'h08, 8'h04, 8'h02, 8'h01}));
      script.push_back(op_line(OP_WRITE, 6'd8, 8'h00));
      script.push_back(op_line(OP_WRITE, 6'd9, 8'hFF));
      // unused opcode carrying write-like fields must not touch column 3
      script.push_back(op_line(OP_UNUSED, 6'd3, 8'h5A));
      // reset speed 2: the third tick moves the window to column 1
      for (int t = 0; t < 3; t++)
         script.push_back(op_line(OP_TICK, '0, '0));
      script.push_back(typed_refresh({8'h00, 8'h80, 8'h40, 8'h20,
                                      8'h10, 8'h08, 8'h04, 8'h02}));
      // fastest speed: every tick steps, then back to horizontal
      script.push_back(csr_line(CSR_TICKS, '0));
      script.push_back(op_line(OP_TICK, '0, '0));
      script.push_back(csr_line(CSR_SCROLL_DIR, 1'b1));
      script.push_back(op_line(OP_REFRESH, '0, '0));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_csr) begin
            settle();
            write_csr(script[i].csr_idx, script[i].csr_val);
         end else begin
            push_request(script[i].req, script[i].typed, script[i].pix);
         end
      end

      // Fill the whole store so any later window reads written columns only
      for (int c = 0; c < COLUMNS; c++) begin
         r = random_request();
         r.opcode       = OP_WRITE;
         r.column_index = IDX_W'(c);
         push_request(r, 1'b0, '0);
      end

      // Randomized phases; the last one runs at the slowest speed
      for (int p = 0; p < 5; p++) begin
         case (p)
            0:       begin dir = 1'b0; step = 8'd0; end
            1:       begin dir = 1'b1; step = 8'd0; end
            2:       begin dir = 1'b1; step = 8'($urandom_range(1, 6)); end
            3:       begin dir = 1'b0; step = 8'($urandom_range(1, 254)); end
            default: begin dir = 1'b1; step = 8'd255; end
         endcase
         settle();
         write_csr(CSR_SCROLL_DIR, CSR_DAT_W'(dir));
         write_csr(CSR_TICKS, step);
         calm = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < 45; n++)
            push_request(random_request(), 1'b0, '0);
      end

      settle();
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* scrolling_dot_matrix_scanner_unit.f */
sv/sdm_pkg.sv
sv/sdm_pattern_mem.sv
sv/sdm_scroll_timer.sv
sv/sdm_frame_scan.sv
sv/scrolling_dot_matrix_scanner_unit.sv
tb/tb.sv
